### design/soc_pkg.sv
// Shared types, constants and helper functions of the status overlay compositor.
package soc_pkg;

  localparam int SOC_COORD_BITS = 12;
  localparam int SOC_MAX_LABEL_CHARS = 12;
  localparam int SOC_CFG_INDEX_BITS = 3;
  localparam int SOC_CFG_DATA_BITS = 60;
  localparam int SOC_GEOM_BITS = 14;
  localparam int SOC_LAYERS = 6;

  // Register indexes of the configuration port.
  localparam logic [SOC_CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH = 3'd0;
  localparam logic [SOC_CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [SOC_CFG_INDEX_BITS-1:0] REG_PHASE_MODE = 3'd2;
  localparam logic [SOC_CFG_INDEX_BITS-1:0] REG_PROGRESS = 3'd3;
  localparam logic [SOC_CFG_INDEX_BITS-1:0] REG_LABEL_LENGTH = 3'd4;
  localparam logic [SOC_CFG_INDEX_BITS-1:0] REG_LABEL_GLYPHS = 3'd5;

  // Phase codes.
  localparam logic [1:0] PHASE_VIEWING = 2'd1;
  localparam logic [1:0] PHASE_FINISHED = 2'd2;

  // Layer numbers, which are also the bit positions of the layer flags.
  localparam int LAYER_BAND = 0;
  localparam int LAYER_ACCENT = 1;
  localparam int LAYER_BAR = 2;
  localparam int LAYER_FILL = 3;
  localparam int LAYER_BOX = 4;
  localparam int LAYER_TEXT = 5;

  localparam logic [8:0] ALPHA_BAND = 9'd90;
  localparam logic [8:0] ALPHA_FULL = 9'd256;
  localparam logic [8:0] ALPHA_BAR = 9'd218;
  localparam logic [8:0] ALPHA_FILL = 9'd243;
  localparam logic [8:0] ALPHA_BOX = 9'd159;
  localparam logic [8:0] ALPHA_TEXT = 9'd243;

  localparam logic [10:0] BAR_MIN_WIDTH = 11'd120;
  localparam logic [11:0] SCALE_STEP = 12'd640;
  localparam logic [4:0] MARGIN = 5'd18;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } soc_rgb_t;

  // Values derived from the configuration registers.
  typedef struct packed {
    logic [11:0] frame_width;
    logic [11:0] frame_height;
    logic [2:0] scale;
    logic [5:0] pitch;
    logic [5:0] cell_width;
    logic [5:0] cell_height;
    logic [3:0] chars;
    logic label_on;
    logic signed [SOC_GEOM_BITS-1:0] bar_start;
    logic signed [SOC_GEOM_BITS-1:0] bar_end;
    logic signed [SOC_GEOM_BITS-1:0] fill_end;
    logic signed [SOC_GEOM_BITS-1:0] box_xend;
    logic signed [SOC_GEOM_BITS-1:0] box_ytop;
    logic signed [SOC_GEOM_BITS-1:0] box_yend;
    logic signed [SOC_GEOM_BITS-1:0] text_x0;
    logic signed [SOC_GEOM_BITS-1:0] text_y0;
    logic [SOC_CFG_DATA_BITS-1:0] glyphs;
    soc_rgb_t accent;
  } soc_geom_t;

  // One classified pixel between front and back.
  typedef struct packed {
    soc_rgb_t pix;
    logic [SOC_LAYERS-1:0] layers;
  } soc_item_t;

  // Glyph bitmaps, row 0 in the top five bits, bit 4 of a row is the leftmost column.
  localparam logic [34:0] GLYPHS [0:17] = '{
    {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
    {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F},
    {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10},
    {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0E},
    {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F},
    {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11},
    {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
    {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h1F},
    {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E},
    {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
    {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F},
    {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E},
    {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},
    {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E},
    {5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
    {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
    {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
    {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E}
  };

  // Lit test of one glyph cell; codes outside one to eighteen draw nothing.
  function automatic logic soc_glyph_bit(input logic [4:0] code, input logic [2:0] row,
                                         input logic [2:0] col);
    logic [34:0] rows;
    logic [5:0] pos;
    logic lit;
    lit = 1'b0;
    if (code >= 5'd1 && code <= 5'd18 && row <= 3'd6 && col <= 3'd4) begin
      rows = GLYPHS[5'(code - 5'd1)];
      pos = 6'd34 - (6'(row) * 6'd5 + 6'(col));
      lit = rows[pos];
    end
    return lit;
  endfunction

  function automatic soc_rgb_t soc_accent(input logic [1:0] phase);
    soc_rgb_t c;
    case (phase)
      PHASE_VIEWING: c = '{r: 8'd255, g: 8'd180, b: 8'd48};
      PHASE_FINISHED: c = '{r: 8'd0, g: 8'd220, b: 8'd255};
      default: c = '{r: 8'd0, g: 8'd255, b: 8'd128};
    endcase
    return c;
  endfunction

  // out = (p*(256-a) + c*a) >> 8, kept to eight bits.
  function automatic logic [7:0] soc_blend(input logic [7:0] p, input logic [7:0] c,
                                           input logic [8:0] a);
    logic [16:0] acc;
    acc = 17'(17'(p) * 17'(9'd256 - a)) + 17'(17'(c) * 17'(a));
    return acc[15:8];
  endfunction

endpackage

### design/soc_config.sv
// Configuration registers of the compositor and the geometry derived from them.
module soc_config #(
  parameter int MAX_LABEL_CHARS = soc_pkg::SOC_MAX_LABEL_CHARS
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic [soc_pkg::SOC_CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [soc_pkg::SOC_CFG_DATA_BITS-1:0] cfg_data,
  output soc_pkg::soc_geom_t geom
);
  import soc_pkg::*;

  localparam logic [3:0] MAX_CHARS = 4'(MAX_LABEL_CHARS);

  logic [11:0] frame_width;
  logic [11:0] frame_height;
  logic [1:0] phase_mode;
  logic [16:0] progress_fraction;
  logic [3:0] label_length;
  logic [59:0] label_glyphs;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= 12'd640;
      frame_height <= 12'd480;
      phase_mode <= 2'd0;
      progress_fraction <= 17'd0;
      label_length <= 4'd0;
      label_glyphs <= 60'd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH: frame_width <= cfg_data[11:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[11:0];
        REG_PHASE_MODE: phase_mode <= cfg_data[1:0];
        REG_PROGRESS: progress_fraction <= cfg_data[16:0];
        REG_LABEL_LENGTH: label_length <= cfg_data[3:0];
        REG_LABEL_GLYPHS: label_glyphs <= cfg_data[59:0];
        default: ;
      endcase
    end
  end

  logic [2:0] quot_640;
  logic [2:0] scale_c;
  logic [23:0] third_prod;
  logic [10:0] third_c;
  logic [10:0] bar_span_c;
  logic [3:0] chars_c;
  logic [9:0] box_span_c;
  logic [16:0] frac_c;
  logic signed [SOC_GEOM_BITS-1:0] width_s;
  logic signed [SOC_GEOM_BITS-1:0] height_s;
  soc_geom_t geom_next;
  logic [10:0] bar_span;
  logic [16:0] frac;
  logic [28:0] fill_prod;

  always_comb begin
    quot_640 = 3'd0;
    for (int k = 1; k <= 6; k++) begin
      if (frame_width >= 12'(k * 640)) quot_640 = 3'(k);
    end
    scale_c = (quot_640 < 3'd2) ? 3'd2 : quot_640;
    // Divide by three as multiply by 2731/8192, exact over twelve bits.
    third_prod = 24'(frame_width) * 24'd2731;
    third_c = third_prod[23:13];
    bar_span_c = (third_c > BAR_MIN_WIDTH) ? third_c : BAR_MIN_WIDTH;
    chars_c = (label_length > MAX_CHARS) ? MAX_CHARS : label_length;
    box_span_c = 10'(10'(scale_c) * (10'(chars_c) * 10'd6 + 10'd9));
    frac_c = (progress_fraction > 17'd65536) ? 17'd65536 : progress_fraction;
    width_s = $signed({2'b00, frame_width});
    height_s = $signed({2'b00, frame_height});

    geom_next = geom;
    geom_next.frame_width = frame_width;
    geom_next.frame_height = frame_height;
    geom_next.scale = scale_c;
    geom_next.pitch = 6'(6'(scale_c) * 6'd6);
    geom_next.cell_width = 6'(6'(scale_c) * 6'd5);
    geom_next.cell_height = 6'(6'(scale_c) * 6'd7);
    geom_next.chars = chars_c;
    geom_next.label_on = (label_length != 4'd0);
    geom_next.bar_start = width_s - $signed({3'b000, bar_span_c}) - 14'sd18;
    geom_next.bar_end = width_s - 14'sd18;
    geom_next.box_xend = 14'sd18 + $signed({4'b0000, box_span_c});
    geom_next.box_ytop = height_s - $signed(14'(scale_c) * 14'd17) - 14'sd18;
    geom_next.box_yend = height_s - 14'sd18;
    geom_next.text_x0 = 14'sd18 + $signed(14'(scale_c) * 14'd5);
    geom_next.text_y0 = height_s - $signed(14'(scale_c) * 14'd12) - 14'sd18;
    geom_next.glyphs = label_glyphs;
    geom_next.accent = soc_accent(phase_mode);
    // Fill end uses the registered bar start and width, so it settles in the cycle after the other fields.
    fill_prod = 29'(29'(bar_span) * 29'(frac)) + 29'd32768;
    geom_next.fill_end = geom.bar_start + $signed({1'b0, fill_prod[28:16]});
  end

  always_ff @(posedge clk) begin
    geom <= geom_next;
    bar_span <= bar_span_c;
    frac <= frac_c;
  end

endmodule

### design/soc_front.sv
// Front part: takes pixels and classifies them against the overlay layers in two stages.
module soc_front #(
  parameter int COORD_BITS = soc_pkg::SOC_COORD_BITS,
  parameter int MAX_LABEL_CHARS = soc_pkg::SOC_MAX_LABEL_CHARS
) (
  input  logic clk,
  input  logic rst,
  input  soc_pkg::soc_geom_t geom,
  input  logic in_valid,
  output logic in_ready,
  input  logic [COORD_BITS-1:0] pixel_x,
  input  logic [COORD_BITS-1:0] pixel_y,
  input  soc_pkg::soc_rgb_t pix_in,
  output logic out_valid,
  input  logic out_ready,
  output soc_pkg::soc_item_t item
);
  import soc_pkg::*;

  localparam int SW = ((COORD_BITS > 13) ? COORD_BITS : 13) + 2;
  localparam int CIW = $clog2(MAX_LABEL_CHARS + 1);

  // Input stage.
  logic in_v;
  logic [COORD_BITS-1:0] in_x;
  logic [COORD_BITS-1:0] in_y;
  soc_rgb_t in_pix;
  // Classification stage.
  logic a_v;
  soc_rgb_t a_pix;
  logic signed [SW-1:0] a_x;
  logic a_inframe;
  logic a_barrow;
  logic [4:0] a_layers;
  logic a_glyph;
  logic [CIW-1:0] a_ci;
  logic [5:0] a_cx;
  logic [5:0] a_dy;

  logic a_ready;
  logic in_stage_ready;

  assign out_valid = a_v;
  assign a_ready = !a_v || out_ready;
  assign in_stage_ready = !in_v || a_ready;
  assign in_ready = in_stage_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (in_stage_ready) begin
      in_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_stage_ready && in_valid) begin
      in_x <= pixel_x;
      in_y <= pixel_y;
      in_pix <= pix_in;
    end
  end

  logic signed [SW-1:0] xs;
  logic signed [SW-1:0] ys;
  logic signed [SW-1:0] dx;
  logic signed [SW-1:0] dy;
  logic inframe;
  logic barrow;
  logic [CIW-1:0] ci;
  logic [9:0] ci_base;
  logic signed [SW-1:0] cx;
  logic glyph_ok;
  logic [4:0] layers;

  always_comb begin
    xs = $signed(SW'({1'b0, in_x}));
    ys = $signed(SW'({1'b0, in_y}));
    inframe = (SW'({1'b0, in_x}) < SW'(geom.frame_width))
           && (SW'({1'b0, in_y}) < SW'(geom.frame_height));
    barrow = (ys >= SW'(18)) && (ys < SW'(28));
    layers[LAYER_BAND] = inframe && (ys < SW'(50));
    layers[LAYER_ACCENT] = inframe && (ys < SW'(4));
    layers[LAYER_BAR] = inframe && barrow && (xs >= SW'(geom.bar_start))
                     && (xs < SW'(geom.bar_end));
    layers[LAYER_FILL] = 1'b0;
    layers[LAYER_BOX] = inframe && geom.label_on && (xs >= SW'(18))
                     && (xs < SW'(geom.box_xend)) && (ys >= SW'(geom.box_ytop))
                     && (ys < SW'(geom.box_yend));
    dx = xs - SW'(geom.text_x0);
    dy = ys - SW'(geom.text_y0);
    // Character index: how many whole character pitches fit below dx.
    ci = '0;
    for (int k = 1; k <= MAX_LABEL_CHARS; k++) begin
      if (dx >= $signed(SW'(10'(k) * 10'(geom.pitch)))) ci = CIW'(k);
    end
    ci_base = 10'(10'(ci) * 10'(geom.pitch));
    cx = dx - $signed(SW'(ci_base));
    glyph_ok = inframe && geom.label_on && (dx >= SW'(0)) && (dy >= SW'(0))
            && (dy < SW'(geom.cell_height)) && (4'(ci) < geom.chars)
            && (cx < SW'(geom.cell_width));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (a_ready) begin
      a_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_v) begin
      a_pix <= in_pix;
      a_x <= xs;
      a_inframe <= inframe;
      a_barrow <= barrow;
      a_layers <= layers;
      a_glyph <= glyph_ok;
      a_ci <= ci;
      a_cx <= cx[5:0];
      a_dy <= dy[5:0];
    end
  end

  // Glyph lookup and fill test, feeding the queue directly.
  logic [4:0] code;
  logic [2:0] col;
  logic [2:0] row;
  logic fill;
  logic text;

  always_comb begin
    code = 5'd0;
    for (int k = 0; k < MAX_LABEL_CHARS; k++) begin
      if (a_ci == CIW'(k)) code = geom.glyphs[5*k +: 5];
    end
    col = 3'd0;
    for (int k = 1; k <= 4; k++) begin
      if (a_cx >= 6'(6'(k) * 6'(geom.scale))) col = 3'(k);
    end
    row = 3'd0;
    for (int k = 1; k <= 6; k++) begin
      if (a_dy >= 6'(6'(k) * 6'(geom.scale))) row = 3'(k);
    end
    text = a_glyph && soc_glyph_bit(code, row, col);
    fill = a_inframe && a_barrow && (a_x >= SW'(geom.bar_start))
        && (a_x < SW'(geom.fill_end));
    item.pix = a_pix;
    item.layers = {text, a_layers[LAYER_BOX], fill, a_layers[LAYER_BAR:LAYER_BAND]};
  end

endmodule

### design/soc_queue.sv
// Short word queue that decouples the front and back parts.
module soc_queue #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  soc_pkg::soc_item_t push_item,
  output logic pop_valid,
  input  logic pop_ready,
  output soc_pkg::soc_item_t pop_item
);
  import soc_pkg::*;

  localparam int PW = $clog2(DEPTH);

  soc_item_t mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0] count;
  logic push;
  logic pop;

  assign push_ready = (count != (PW+1)'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_item = mem[rd_ptr];
  assign push = push_valid && push_ready;
  assign pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

endmodule

### design/soc_back.sv
// Back part: six blend stages, one overlay layer each, the last one holding the result.
module soc_back (
  input  logic clk,
  input  logic rst,
  input  soc_pkg::soc_rgb_t accent,
  input  logic in_valid,
  output logic in_ready,
  input  soc_pkg::soc_item_t item,
  output logic out_valid,
  input  logic out_ready,
  output soc_pkg::soc_rgb_t pix_out
);
  import soc_pkg::*;

  logic stage_v [SOC_LAYERS];
  soc_item_t stage_item [SOC_LAYERS];
  logic stage_ready [SOC_LAYERS];

  assign in_ready = stage_ready[0];
  assign out_valid = stage_v[SOC_LAYERS-1];
  assign pix_out = stage_item[SOC_LAYERS-1].pix;

  for (genvar l = 0; l < SOC_LAYERS; l++) begin : g_layer
    logic prev_v;
    soc_item_t prev_item;
    logic next_ready;
    soc_rgb_t colour;
    logic [8:0] alpha;
    soc_item_t blended;

    if (l == 0) begin : g_first
      assign prev_v = in_valid;
      assign prev_item = item;
    end else begin : g_rest
      assign prev_v = stage_v[l-1];
      assign prev_item = stage_item[l-1];
    end

    if (l == SOC_LAYERS - 1) begin : g_last
      assign next_ready = out_ready;
    end else begin : g_mid
      assign next_ready = stage_ready[l+1];
    end

    assign stage_ready[l] = !stage_v[l] || next_ready;

    always_comb begin
      unique case (l)
        LAYER_BAND: begin
          colour = '0;
          alpha = ALPHA_BAND;
        end
        LAYER_ACCENT: begin
          colour = accent;
          alpha = ALPHA_FULL;
        end
        LAYER_BAR: begin
          colour = '{r: 8'd60, g: 8'd60, b: 8'd72};
          alpha = ALPHA_BAR;
        end
        LAYER_FILL: begin
          colour = accent;
          alpha = ALPHA_FILL;
        end
        LAYER_BOX: begin
          colour = '{r: 8'd6, g: 8'd8, b: 8'd14};
          alpha = ALPHA_BOX;
        end
        default: begin
          colour = '{r: 8'd255, g: 8'd255, b: 8'd255};
          alpha = ALPHA_TEXT;
        end
      endcase
      blended = prev_item;
      if (prev_item.layers[l]) begin
        blended.pix.r = soc_blend(prev_item.pix.r, colour.r, alpha);
        blended.pix.g = soc_blend(prev_item.pix.g, colour.g, alpha);
        blended.pix.b = soc_blend(prev_item.pix.b, colour.b, alpha);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stage_v[l] <= 1'b0;
      end else if (stage_ready[l]) begin
        stage_v[l] <= prev_v;
      end
    end

    always_ff @(posedge clk) begin
      if (stage_ready[l] && prev_v) begin
        stage_item[l] <= blended;
      end
    end
  end

endmodule

### design/status_overlay_compositor_unit.sv
// Status overlay compositor: top level joining configuration, front, queue and back.
// A pixel word passes the two front stages, one queue entry and the six blend stages
// before its result word is valid.
// Throughput: one pixel word per cycle; each stage holds its word only while the next is full.
// Reset (rst, synchronous, active high) empties every stage and the queue and sets the
// registers to a 640 by 480 frame, growth phase, no progress and no label.
module status_overlay_compositor_unit #(
  parameter int COORD_BITS = soc_pkg::SOC_COORD_BITS,
  parameter int MAX_LABEL_CHARS = soc_pkg::SOC_MAX_LABEL_CHARS
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic [soc_pkg::SOC_CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [soc_pkg::SOC_CFG_DATA_BITS-1:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  logic [COORD_BITS-1:0] pixel_x,
  input  logic [COORD_BITS-1:0] pixel_y,
  input  logic [7:0] red_in,
  input  logic [7:0] green_in,
  input  logic [7:0] blue_in,
  output logic out_valid,
  input  logic out_ready,
  output logic [7:0] red_out,
  output logic [7:0] green_out,
  output logic [7:0] blue_out
);
  import soc_pkg::*;

  // The geometry is rebuilt from the registers every cycle; the fill edge passes one more
  // register, which lines up with the front stage that first uses it.
  soc_geom_t geom;
  soc_rgb_t pix_in;
  soc_rgb_t pix_out;

  logic front_valid;
  logic front_ready;
  soc_item_t front_item;
  logic back_valid;
  logic back_ready;
  soc_item_t back_item;

  assign pix_in = '{r: red_in, g: green_in, b: blue_in};
  assign red_out = pix_out.r;
  assign green_out = pix_out.g;
  assign blue_out = pix_out.b;

  soc_config #(
    .MAX_LABEL_CHARS(MAX_LABEL_CHARS)
  ) u_config (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .geom(geom)
  );

  // The front part decides for each pixel which of the six layers cover it.
  soc_front #(
    .COORD_BITS(COORD_BITS),
    .MAX_LABEL_CHARS(MAX_LABEL_CHARS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .geom(geom),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .pixel_x(pixel_x),
    .pixel_y(pixel_y),
    .pix_in(pix_in),
    .out_valid(front_valid),
    .out_ready(front_ready),
    .item(front_item)
  );

  // The queue lets the front keep taking pixels while the output stalls, until its four entries are full.
  soc_queue #(
    .DEPTH(4)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push_valid(front_valid),
    .push_ready(front_ready),
    .push_item(front_item),
    .pop_valid(back_valid),
    .pop_ready(back_ready),
    .pop_item(back_item)
  );

  // The back part applies the layers in order, one blend per stage.
  soc_back u_back (
    .clk(clk),
    .rst(rst),
    .accent(geom.accent),
    .in_valid(back_valid),
    .in_ready(back_ready),
    .item(back_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .pix_out(pix_out)
  );

endmodule
